// File: rtl/core/cle_pkg.sv
// Shared constants and types for the console line editor.
// No dependencies.
package cle_pkg;

  localparam int LINE_LEN_DEF = 64;

  localparam logic [7:0] KEY_BACKSPACE = 8'h08;
  localparam logic [7:0] KEY_KILL      = 8'h15;
  localparam logic [7:0] KEY_NEWLINE   = 8'h0A;
  localparam logic [7:0] KEY_EOF       = 8'h04;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } cle_state_t;

endpackage

// File: rtl/core/console_line_editor.sv
// Console line editor: keyboard line discipline with a RAM line store.
// A raw byte or end-of-file marker shows on the output in the cycle after its
// key is taken. A finished line enters the drain state, is read from the RAM,
// then output one byte per cycle unless m_tready stalls. Keys are taken one per
// cycle when the output is free, none while a line drains. Reset (rst,
// synchronous) clears control state, line length and raw_mode, not the store.
module console_line_editor #(
  parameter int LINE_LEN = cle_pkg::LINE_LEN_DEF,
  localparam int AW = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1,
  localparam int LW = $clog2(LINE_LEN + 1)
) (
  input  logic       clk,
  input  logic       rst,
  // configuration: raw_mode
  input  logic       cfg_we,
  input  logic       cfg_wdata,   // [0] raw_mode
  // key input
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // [7:0] key_byte
  // delivered bytes
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // [7:0] out_byte
  output logic       m_tlast,     // end_of_run
  output logic       m_tuser      // [0] end_of_file
);

  localparam logic [LW-1:0] LEN_FULL = LW'(LINE_LEN);
  localparam logic [LW-1:0] LEN_ONE  = LW'(1);

  cle_pkg::cle_state_t state, state_next;

  logic          raw_mode;
  logic [LW-1:0] line_len;     // characters held in the store
  logic [LW-1:0] drain_n;      // bytes to deliver for the finished line
  logic [LW-1:0] rd_idx;       // next store entry to read while draining
  logic          fetch_vld;    // RAM read data holds an undelivered byte
  logic          fetch_last;   // ... and it is the last byte of the line

  logic          out_free;
  logic          accept;
  logic          issue;
  logic          load_drain;
  logic          load_key;
  logic          key_is_eol;
  logic [LW-1:0] len_inc;
  logic [LW-1:0] line_n;
  logic          line_done;
  logic          ram_we;
  logic [7:0]    ram_q;

  // Output register is free when empty or being taken this cycle.
  assign out_free = !m_tvalid || m_tready;

  // Keys are only taken when idle and a result slot is free, so a key that
  // produces a byte (raw, end-of-file) always has room.
  assign s_tready = (state == cle_pkg::ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  // Cooked-mode decode of the incoming key.
  assign key_is_eol = (s_tdata == cle_pkg::KEY_NEWLINE) || (s_tdata == cle_pkg::KEY_EOF);
  assign len_inc    = line_len + LEN_ONE;
  // Ctrl-D is stored but never delivered.
  assign line_n     = (s_tdata == cle_pkg::KEY_EOF) ? (len_inc - LEN_ONE) : len_inc;

  // In cooked mode, any byte other than backspace and kill is appended.
  assign ram_we = accept && !raw_mode &&
                  (s_tdata != cle_pkg::KEY_BACKSPACE) && (s_tdata != cle_pkg::KEY_KILL);
  assign line_done = ram_we && (key_is_eol || (len_inc == LEN_FULL));

  // Raw bytes and the empty-line end-of-file marker go straight to the output.
  assign load_key = accept && (raw_mode || (line_done && (line_n == '0)));

  // Drain pipeline: RAM read, then output register. A read is issued when the
  // fetched byte (if any) moves out this cycle: one byte per cycle unless stalled.
  assign load_drain = (state == cle_pkg::ST_DRAIN) && fetch_vld && out_free;
  assign issue      = (state == cle_pkg::ST_DRAIN) && (rd_idx != drain_n) &&
                      (!fetch_vld || out_free);

  cle_line_ram #(
    .DEPTH (LINE_LEN)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (line_len[AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (issue),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (ram_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      cle_pkg::ST_IDLE: begin
        if (line_done && (line_n != '0)) begin
          state_next = cle_pkg::ST_DRAIN;
        end
      end
      cle_pkg::ST_DRAIN: begin
        if (load_drain && fetch_last) begin
          state_next = cle_pkg::ST_IDLE;
        end
      end
      default: state_next = cle_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= cle_pkg::ST_IDLE;
      raw_mode   <= 1'b0;
      line_len   <= '0;
      rd_idx     <= '0;
      fetch_vld  <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        raw_mode <= cfg_wdata;
      end

      // Line length editing
      if (accept && !raw_mode) begin
        if (s_tdata == cle_pkg::KEY_BACKSPACE) begin
          if (line_len != '0) begin
            line_len <= line_len - LEN_ONE;
          end
        end else if (s_tdata == cle_pkg::KEY_KILL) begin
          line_len <= '0;
        end else if (line_done) begin
          line_len <= '0;
        end else begin
          line_len <= len_inc;
        end
      end

      // Read pointer restarts at each finished line
      if (line_done) begin
        rd_idx <= '0;
      end else if (issue) begin
        rd_idx <= rd_idx + LEN_ONE;
      end

      if (issue) begin
        fetch_vld <= 1'b1;
      end else if (load_drain) begin
        fetch_vld <= 1'b0;
      end

      if (load_key || load_drain) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (line_done) begin
      drain_n <= line_n;
    end
    if (issue) begin
      fetch_last <= (rd_idx == (drain_n - LEN_ONE));
    end
    if (load_drain) begin
      m_tdata <= ram_q;
      m_tlast <= fetch_last;
      m_tuser <= 1'b0;
    end else if (load_key) begin
      m_tdata <= raw_mode ? s_tdata : 8'h00;
      m_tlast <= 1'b1;
      m_tuser <= !raw_mode;
    end
  end

endmodule

// File: rtl/core/cle_line_ram.sv
// Line store: simple dual-port synchronous RAM, one write and one read port.
// Read data is registered and holds while rd_en is low. Uses no package items.
module cle_line_ram #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
